### rtl/gf_pkg.sv
// Package for the 2-D Gaussian fusion block: payload types and fixed-point helpers.
// No dependencies; every other file imports it.
package gf_pkg;

    localparam int unsigned DW = 32;

    typedef logic signed [DW-1:0] t_word;
    typedef logic signed [2*DW-1:0] t_prod;

    typedef struct packed {
        t_word first_mean_x;
        t_word first_mean_y;
        t_word first_cov_00;
        t_word first_cov_01;
        t_word first_cov_10;
        t_word first_cov_11;
        t_word second_mean_x;
        t_word second_mean_y;
        t_word second_cov_00;
        t_word second_cov_01;
        t_word second_cov_10;
        t_word second_cov_11;
    } t_in;

    typedef struct packed {
        t_word fused_mean_x;
        t_word fused_mean_y;
        t_word fused_cov_00;
        t_word fused_cov_01;
        t_word fused_cov_10;
        t_word fused_cov_11;
        logic  singular;
    } t_out;

    // Values handed from the front end to the back end around the reciprocal.
    typedef struct packed {
        logic  singular;
        t_word p00;
        t_word p01;
        t_word p10;
        t_word p11;
        t_word m1x;
        t_word m1y;
        t_word dx;
        t_word dy;
        t_word a00;
        t_word a01;
        t_word a10;
        t_word a11;
    } t_mid;

    localparam t_word MAX_W = {1'b0, {(DW-1){1'b1}}};
    localparam t_word MIN_W = {1'b1, {(DW-1){1'b0}}};

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? MIN_W : MAX_W;
        end
        return s[DW-1:0];
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? MIN_W : MAX_W;
        end
        return s[DW-1:0];
    endfunction

    // Two products summed with 64-bit saturation, floor-shifted, then clamped to 32 bits.
    function automatic t_word dot_fin(input t_prod x, input t_prod y, input int unsigned f);
        logic signed [2*DW:0]   s;
        t_prod                  s64;
        t_prod                  sh;
        s = {x[2*DW-1], x} + {y[2*DW-1], y};
        if (s[2*DW] != s[2*DW-1]) begin
            s64 = s[2*DW] ? {1'b1, {(2*DW-1){1'b0}}} : {1'b0, {(2*DW-1){1'b1}}};
        end else begin
            s64 = s[2*DW-1:0];
        end
        sh = s64 >>> f;
        if (sh > t_prod'(MAX_W)) begin
            return MAX_W;
        end
        if (sh < t_prod'(MIN_W)) begin
            return MIN_W;
        end
        return sh[DW-1:0];
    endfunction

endpackage

### rtl/gf_if.sv
// Valid/ready channel carrying one fusion request or one fusion result.
// Depends on gf_pkg for the payload types.
interface gf_in_if import gf_pkg::*; ();
    logic valid;
    logic ready;
    t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gf_out_if import gf_pkg::*; ();
    logic valid;
    logic ready;
    t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/gf_front.sv
// Front end: covariance sum, determinant and adjugate products, three stages.
// Depends on gf_pkg.
module gf_front import gf_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_req,
    output logic  o_valid,
    output t_word o_det,
    output t_mid  o_mid
);

    logic  r_v1, r_v2, r_v3;
    t_word r1_s00, r1_s01, r1_s10, r1_s11, r1_dx, r1_dy, r1_m1x, r1_m1y;
    t_word r1_a00, r1_a01, r1_a10, r1_a11;
    t_prod r2_d1, r2_d2, r2_q0, r2_q1, r2_q2, r2_q3, r2_q4, r2_q5, r2_q6, r2_q7;
    t_word r2_dx, r2_dy, r2_m1x, r2_m1y, r2_a00, r2_a01, r2_a10, r2_a11;
    t_word r3_det;
    t_mid  r3_mid;
    t_word n01, n10, n_det;

    assign n01   = sat_sub('0, r1_s01);
    assign n10   = sat_sub('0, r1_s10);
    assign n_det = dot_fin(r2_d1, -r2_d2, FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s00 <= sat_add(i_req.first_cov_00, i_req.second_cov_00);
            r1_s01 <= sat_add(i_req.first_cov_01, i_req.second_cov_01);
            r1_s10 <= sat_add(i_req.first_cov_10, i_req.second_cov_10);
            r1_s11 <= sat_add(i_req.first_cov_11, i_req.second_cov_11);
            r1_dx  <= sat_sub(i_req.second_mean_x, i_req.first_mean_x);
            r1_dy  <= sat_sub(i_req.second_mean_y, i_req.first_mean_y);
            r1_m1x <= i_req.first_mean_x;
            r1_m1y <= i_req.first_mean_y;
            r1_a00 <= i_req.first_cov_00;
            r1_a01 <= i_req.first_cov_01;
            r1_a10 <= i_req.first_cov_10;
            r1_a11 <= i_req.first_cov_11;

            r2_d1  <= r1_s00 * r1_s11;
            r2_d2  <= r1_s01 * r1_s10;
            r2_q0  <= r1_a00 * r1_s11;
            r2_q1  <= r1_a01 * n10;
            r2_q2  <= r1_a00 * n01;
            r2_q3  <= r1_a01 * r1_s00;
            r2_q4  <= r1_a10 * r1_s11;
            r2_q5  <= r1_a11 * n10;
            r2_q6  <= r1_a10 * n01;
            r2_q7  <= r1_a11 * r1_s00;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_m1x <= r1_m1x;
            r2_m1y <= r1_m1y;
            r2_a00 <= r1_a00;
            r2_a01 <= r1_a01;
            r2_a10 <= r1_a10;
            r2_a11 <= r1_a11;

            r3_det          <= n_det;
            r3_mid.singular <= (n_det == '0);
            r3_mid.p00      <= dot_fin(r2_q0, r2_q1, FRAC_BITS);
            r3_mid.p01      <= dot_fin(r2_q2, r2_q3, FRAC_BITS);
            r3_mid.p10      <= dot_fin(r2_q4, r2_q5, FRAC_BITS);
            r3_mid.p11      <= dot_fin(r2_q6, r2_q7, FRAC_BITS);
            r3_mid.m1x      <= r2_m1x;
            r3_mid.m1y      <= r2_m1y;
            r3_mid.dx       <= r2_dx;
            r3_mid.dy       <= r2_dy;
            r3_mid.a00      <= r2_a00;
            r3_mid.a01      <= r2_a01;
            r3_mid.a10      <= r2_a10;
            r3_mid.a11      <= r2_a11;
        end
    end

    assign o_valid = r_v3;
    assign o_det   = r3_det;
    assign o_mid   = r3_mid;

endmodule

### rtl/gf_recip.sv
// Pipelined restoring divider forming 2^(2*FRAC_BITS)/det, one quotient bit per stage.
// Depends on gf_pkg; carries the rest of the request alongside.
module gf_recip import gf_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_word i_det,
    input  t_mid  i_mid,
    output logic  o_valid,
    output t_word o_r,
    output t_mid  o_mid
);

    localparam int unsigned QW = 2 * FRAC_BITS + 1;

    logic                r_v   [QW+1];
    logic                r_neg [QW+1];
    logic [DW-1:0]       r_mag [QW+1];
    logic [DW-1:0]       r_rem [QW+1];
    logic [QW-1:0]       r_q   [QW+1];
    t_mid                r_mid [QW+1];
    logic                r_vo;
    t_word               r_r;
    t_mid                r_mido;
    logic [2*DW-1:0]     q_ext;

    // Entry stage: magnitude of det; a zero det divides by one and is discarded later.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_det[DW-1];
            if (i_det == '0) begin
                r_mag[0] <= DW'(1);
            end else begin
                r_mag[0] <= i_det[DW-1] ? DW'(-i_det) : DW'(i_det);
            end
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_mid[0] <= i_mid;
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        assign trial = {r_rem[g], (g == 0) ? 1'b1 : 1'b0};
        assign ge    = trial >= {1'b0, r_mag[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                r_mag[g+1] <= r_mag[g];
                r_rem[g+1] <= ge ? DW'(trial - {1'b0, r_mag[g]}) : trial[DW-1:0];
                r_q[g+1]   <= {r_q[g][QW-2:0], ge};
                r_mid[g+1] <= r_mid[g];
            end
        end
    end

    assign q_ext = {{(2*DW-QW){1'b0}}, r_q[QW]};

    // Final stage: apply the sign and clamp to the word range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg[QW]) begin
                r_r <= (q_ext > {{DW{1'b0}}, MAX_W}) ? MAX_W : t_word'(q_ext[DW-1:0]);
            end else if (q_ext > {{DW{1'b0}}, MIN_W}) begin
                r_r <= MIN_W;
            end else begin
                r_r <= t_word'(-q_ext[DW-1:0]);
            end
            r_mido <= r_mid[QW];
        end
    end

    assign o_valid = r_vo;
    assign o_r     = r_r;
    assign o_mid   = r_mido;

endmodule

### rtl/gf_back.sv
// Back end: gain from the reciprocal, then fused mean and covariance, four stages.
// Depends on gf_pkg.
module gf_back import gf_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_word i_r,
    input  t_mid  i_mid,
    output logic  o_valid,
    output t_out  o_res
);

    logic  r_v1, r_v2, r_v3, r_v4;
    t_prod r1_kp0, r1_kp1, r1_kp2, r1_kp3;
    t_mid  r1_mid, r2_mid, r3_mid;
    t_word r2_k00, r2_k01, r2_k10, r2_k11;
    t_prod r3_e [12];
    t_out  r4_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kp0 <= i_mid.p00 * i_r;
            r1_kp1 <= i_mid.p01 * i_r;
            r1_kp2 <= i_mid.p10 * i_r;
            r1_kp3 <= i_mid.p11 * i_r;
            r1_mid <= i_mid;

            r2_k00 <= dot_fin(r1_kp0, '0, FRAC_BITS);
            r2_k01 <= dot_fin(r1_kp1, '0, FRAC_BITS);
            r2_k10 <= dot_fin(r1_kp2, '0, FRAC_BITS);
            r2_k11 <= dot_fin(r1_kp3, '0, FRAC_BITS);
            r2_mid <= r1_mid;

            r3_e[0]  <= r2_k00 * r2_mid.dx;
            r3_e[1]  <= r2_k01 * r2_mid.dy;
            r3_e[2]  <= r2_k10 * r2_mid.dx;
            r3_e[3]  <= r2_k11 * r2_mid.dy;
            r3_e[4]  <= r2_k00 * r2_mid.a00;
            r3_e[5]  <= r2_k01 * r2_mid.a10;
            r3_e[6]  <= r2_k00 * r2_mid.a01;
            r3_e[7]  <= r2_k01 * r2_mid.a11;
            r3_e[8]  <= r2_k10 * r2_mid.a00;
            r3_e[9]  <= r2_k11 * r2_mid.a10;
            r3_e[10] <= r2_k10 * r2_mid.a01;
            r3_e[11] <= r2_k11 * r2_mid.a11;
            r3_mid   <= r2_mid;

            if (r3_mid.singular) begin
                r4_res.fused_mean_x <= '0;
                r4_res.fused_mean_y <= '0;
                r4_res.fused_cov_00 <= '0;
                r4_res.fused_cov_01 <= '0;
                r4_res.fused_cov_10 <= '0;
                r4_res.fused_cov_11 <= '0;
                r4_res.singular     <= 1'b1;
            end else begin
                r4_res.fused_mean_x <= sat_add(r3_mid.m1x,
                                               dot_fin(r3_e[0], r3_e[1], FRAC_BITS));
                r4_res.fused_mean_y <= sat_add(r3_mid.m1y,
                                               dot_fin(r3_e[2], r3_e[3], FRAC_BITS));
                r4_res.fused_cov_00 <= sat_sub(r3_mid.a00,
                                               dot_fin(r3_e[4], r3_e[5], FRAC_BITS));
                r4_res.fused_cov_01 <= sat_sub(r3_mid.a01,
                                               dot_fin(r3_e[6], r3_e[7], FRAC_BITS));
                r4_res.fused_cov_10 <= sat_sub(r3_mid.a10,
                                               dot_fin(r3_e[8], r3_e[9], FRAC_BITS));
                r4_res.fused_cov_11 <= sat_sub(r3_mid.a11,
                                               dot_fin(r3_e[10], r3_e[11], FRAC_BITS));
                r4_res.singular     <= 1'b0;
            end
        end
    end

    assign o_valid = r_v4;
    assign o_res   = r4_res;

endmodule

### rtl/gaussian_fusion_2d.sv
// Fusion of two 2-D Gaussians: gain through the adjugate and one reciprocal of det(A+B).
// One request per cycle is accepted while the output is not stalled.
// The depth is set by the reciprocal, which resolves one quotient bit per pipeline stage.
// A stall at the output holds every stage at once; nothing is dropped or repeated.
// Reset is synchronous and active low; it clears the valid bits, not the data registers.
// Depends on gf_pkg, gf_if, gf_front, gf_recip and gf_back.
module gaussian_fusion_2d import gf_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gf_in_if.sink       i_req,
    gf_out_if.source    o_res
);

    // The whole pipeline advances together whenever the output register is empty
    // or being drained, so a new request enters in the same cycle a result leaves.
    logic  en;
    logic  f_valid, d_valid, b_valid;
    t_word f_det, d_r;
    t_mid  f_mid, d_mid;
    t_out  b_res;

    assign en          = !b_valid || o_res.ready;
    assign i_req.ready = en;

    // Sum of covariances, determinant and the adjugate products A*adj(S).
    gf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_req   (i_req.payload),
        .o_valid (f_valid),
        .o_det   (f_det),
        .o_mid   (f_mid)
    );

    // Reciprocal of the determinant; the rest of the request rides alongside.
    gf_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_det   (f_det),
        .i_mid   (f_mid),
        .o_valid (d_valid),
        .o_r     (d_r),
        .o_mid   (d_mid)
    );

    // Gain, fused mean and fused covariance; its last register is the output register.
    gf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_r     (d_r),
        .i_mid   (d_mid),
        .o_valid (b_valid),
        .o_res   (b_res)
    );

    assign o_res.valid   = b_valid;
    assign o_res.payload = b_res;

    // A singular sum must come out with every numeric field cleared.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_valid && b_res.singular) |->
            (b_res.fused_mean_x == '0 && b_res.fused_mean_y == '0 &&
             b_res.fused_cov_00 == '0 && b_res.fused_cov_01 == '0 &&
             b_res.fused_cov_10 == '0 && b_res.fused_cov_11 == '0))
        else $error("singular result carries nonzero fields");

    // A held result must block new requests, or the pipeline would overrun it.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_valid && !o_res.ready) |-> !i_req.ready)
        else $error("request taken while output is stalled");

    // The output is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !b_valid)
        else $error("result valid right after reset");

    // While the pipeline advances with no request offered, the first front stage holds no item in the next cycle.
    a_front_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !(i_req.valid)) |=> !u_front.r_v1)
        else $error("front stage valid without a request");

endmodule

### dv/tb_top.sv
// Self-checking bench for gaussian_fusion_2d: random and corner fusion requests.
// Depends on gf_pkg, gf_if and the fusion RTL; a class predicts and checks results.
module tb_top;
    import gf_pkg::*;

    localparam int unsigned FB = 16;
    localparam int LATENCY = 2 * FB + 10;
    localparam int N_RANDOM = 1500;

    logic i_clk;
    logic i_rst_n;

    gf_in_if  req_if ();
    gf_out_if res_if ();

    gaussian_fusion_2d #(.FRAC_BITS(FB)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Fixed-point arithmetic of the fusion, done in 64-bit integers.
    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;

    function automatic longint clamp_word(input longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    // Exact sum of two products, clamped to 64 bits, floored and clamped to 32 bits.
    function automatic longint prod_sum(input longint a, input longint b,
                                        input longint c, input longint d);
        logic signed [65:0] s;
        longint s64;
        s = 66'(a * b) + 66'(c * d);
        if (s > 66'sh0_7FFF_FFFF_FFFF_FFFF) s64 = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (s < -66'sh0_8000_0000_0000_0000) s64 = 64'sh8000_0000_0000_0000;
        else s64 = s[63:0];
        return clamp_word(s64 >>> FB);
    endfunction

    function automatic longint inv_det(input longint det);
        longint unsigned mag;
        longint unsigned q;
        mag = det < 0 ? -det : det;
        q = (64'd1 << (2 * FB)) / mag;
        if (det > 0) return q > 64'd2147483647 ? W_MAX : longint'(q);
        return q > 64'd2147483648 ? W_MIN : -longint'(q);
    endfunction

    function automatic t_out fuse(input t_in r);
        longint m1x, m1y, a00, a01, a10, a11, s00, s01, s10, s11;
        longint det, rc, k00, k01, k10, k11, dx, dy;
        t_out o;
        m1x = longint'(r.first_mean_x); m1y = longint'(r.first_mean_y);
        a00 = longint'(r.first_cov_00); a01 = longint'(r.first_cov_01);
        a10 = longint'(r.first_cov_10); a11 = longint'(r.first_cov_11);
        s00 = clamp_word(a00 + longint'(r.second_cov_00));
        s01 = clamp_word(a01 + longint'(r.second_cov_01));
        s10 = clamp_word(a10 + longint'(r.second_cov_10));
        s11 = clamp_word(a11 + longint'(r.second_cov_11));
        o = '0;
        det = prod_sum(s00, s11, -s01, s10);
        if (det == 0) begin
            o.singular = 1'b1;
            return o;
        end
        rc = inv_det(det);
        k00 = prod_sum(prod_sum(a00, s11, a01, clamp_word(-s10)), rc, 0, 0);
        k01 = prod_sum(prod_sum(a00, clamp_word(-s01), a01, s00), rc, 0, 0);
        k10 = prod_sum(prod_sum(a10, s11, a11, clamp_word(-s10)), rc, 0, 0);
        k11 = prod_sum(prod_sum(a10, clamp_word(-s01), a11, s00), rc, 0, 0);
        dx = clamp_word(longint'(r.second_mean_x) - m1x);
        dy = clamp_word(longint'(r.second_mean_y) - m1y);
        o.fused_mean_x = t_word'(clamp_word(m1x + prod_sum(k00, dx, k01, dy)));
        o.fused_mean_y = t_word'(clamp_word(m1y + prod_sum(k10, dx, k11, dy)));
        o.fused_cov_00 = t_word'(clamp_word(a00 - prod_sum(k00, a00, k01, a10)));
        o.fused_cov_01 = t_word'(clamp_word(a01 - prod_sum(k00, a01, k01, a11)));
        o.fused_cov_10 = t_word'(clamp_word(a10 - prod_sum(k10, a00, k11, a10)));
        o.fused_cov_11 = t_word'(clamp_word(a11 - prod_sum(k10, a01, k11, a11)));
        return o;
    endfunction

    // Holds the fused results still owed by the block, oldest first.
    class fusion_scoreboard;
        t_out pending[$];
        int   errors;

        function void note_request(input t_in r);
            pending.push_back(fuse(r));
        endfunction

        function void check_result(input t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.singular !== want.singular)
                $display("%0t: singular expected %b actual %b", $time, want.singular, got.singular);
            if (got.fused_mean_x !== want.fused_mean_x)
                $display("%0t: mean_x expected %h actual %h", $time,
                         want.fused_mean_x, got.fused_mean_x);
            if (got.fused_mean_y !== want.fused_mean_y)
                $display("%0t: mean_y expected %h actual %h", $time,
                         want.fused_mean_y, got.fused_mean_y);
            if (got.fused_cov_00 !== want.fused_cov_00)
                $display("%0t: cov_00 expected %h actual %h", $time,
                         want.fused_cov_00, got.fused_cov_00);
            if (got.fused_cov_01 !== want.fused_cov_01)
                $display("%0t: cov_01 expected %h actual %h", $time,
                         want.fused_cov_01, got.fused_cov_01);
            if (got.fused_cov_10 !== want.fused_cov_10)
                $display("%0t: cov_10 expected %h actual %h", $time,
                         want.fused_cov_10, got.fused_cov_10);
            if (got.fused_cov_11 !== want.fused_cov_11)
                $display("%0t: cov_11 expected %h actual %h", $time,
                         want.fused_cov_11, got.fused_cov_11);
            if (got !== want) errors++;
        endfunction
    endclass

    fusion_scoreboard board = new();

    // Idling is switched off for a stretch in the middle of the run, and the
    // receiver is forced to hold off for a long stretch to fill the pipeline.
    // The sender raises hold_off once; the receiver clears it when the hold starts.
    bit calm;
    bit hold_off;
    bit sending_done;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // A word biased toward the values that exercise saturation and rounding.
    function automatic t_word pick_word(input int mode);
        case ($urandom_range(0, 9))
            0: return MAX_W;
            1: return MIN_W;
            2: return t_word'($urandom_range(0, 3)) - 1;
            default: begin
                case (mode)
                    0: return $urandom;
                    1: return $signed($urandom) >>> $urandom_range(4, 14);
                    default: return $signed($urandom) >>> $urandom_range(10, 18);
                endcase
            end
        endcase
    endfunction

    // Well-behaved requests use near-symmetric positive covariances of modest size;
    // the rest are raw noise or deliberately singular sums.
    function automatic t_in make_request();
        t_in r;
        int kind;
        t_word v;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            r.first_mean_x  = pick_word(2);
            r.first_mean_y  = pick_word(2);
            r.second_mean_x = pick_word(2);
            r.second_mean_y = pick_word(2);
            r.first_cov_00  = $urandom_range(1 << 12, 1 << 20);
            r.first_cov_11  = $urandom_range(1 << 12, 1 << 20);
            r.second_cov_00 = $urandom_range(1 << 12, 1 << 20);
            r.second_cov_11 = $urandom_range(1 << 12, 1 << 20);
            v = $signed($urandom) >>> 20;
            r.first_cov_01 = v;
            r.first_cov_10 = v;
            v = $signed($urandom) >>> 20;
            r.second_cov_01 = v;
            r.second_cov_10 = v + t_word'($urandom_range(0, 2)) - 1;
        end else if (kind < 70) begin
            // The sum has equal rows, so its determinant is zero.
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            v = $urandom_range(0, 1 << 18);
            r.first_cov_00 = v; r.first_cov_01 = v; r.first_cov_10 = v;
            r.first_cov_11 = v;
            r.second_cov_00 = '0; r.second_cov_01 = '0;
            r.second_cov_10 = '0; r.second_cov_11 = '0;
        end else begin
            r.first_mean_x  = pick_word(0); r.first_mean_y  = pick_word(0);
            r.first_cov_00  = pick_word(1); r.first_cov_01  = pick_word(1);
            r.first_cov_10  = pick_word(1); r.first_cov_11  = pick_word(1);
            r.second_mean_x = pick_word(0); r.second_mean_y = pick_word(0);
            r.second_cov_00 = pick_word(1); r.second_cov_01 = pick_word(1);
            r.second_cov_10 = pick_word(1); r.second_cov_11 = pick_word(1);
        end
        return r;
    endfunction

    // Offers one request and holds it until the block takes it.
    task automatic send_request(input t_in r, input bit may_idle);
        while (may_idle && !calm && $urandom_range(0, 99) < 36) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_request(r);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // Directed corners: extremes of every field, identities, singular sums.
    task automatic run_directed();
        t_in r;
        r = '0;
        send_request(r, 1'b0);                    // all zero: singular
        r = {12{MAX_W}};
        send_request(r, 1'b0);
        r = {12{MIN_W}};
        send_request(r, 1'b0);
        r = {MAX_W, MIN_W, MAX_W, MIN_W, MIN_W, MAX_W,
             MIN_W, MAX_W, MIN_W, MAX_W, MAX_W, MIN_W};
        send_request(r, 1'b0);
        r = '0;                                   // unit covariances, tiny means
        r.first_cov_00 = 32'sh1_0000; r.first_cov_11 = 32'sh1_0000;
        r.second_cov_00 = 32'sh1_0000; r.second_cov_11 = 32'sh1_0000;
        r.first_mean_x = 32'sh2_0000; r.second_mean_y = -32'sh3_0000;
        send_request(r, 1'b0);
        r.first_cov_00 = 32'sd1; r.first_cov_11 = 32'sd1;  // determinant below one lsb
        r.second_cov_00 = 32'sd0; r.second_cov_11 = 32'sd0;
        send_request(r, 1'b0);
        r.first_cov_00 = 32'sd256; r.first_cov_11 = 32'sd257;  // tiny det, huge reciprocal
        send_request(r, 1'b0);
        r.first_cov_00 = -32'sd256;                            // negative determinant
        send_request(r, 1'b0);
        r.first_mean_x = MIN_W; r.second_mean_x = MAX_W;       // saturating difference
        r.first_mean_y = MAX_W; r.second_mean_y = MIN_W;
        r.first_cov_00 = 32'sh1_0000; r.first_cov_11 = 32'sh1_0000;
        send_request(r, 1'b0);
        r.first_cov_01 = MAX_W; r.first_cov_10 = MIN_W;
        send_request(r, 1'b0);
        r = {12{32'shFFFF_FFFF}};
        send_request(r, 1'b0);
        r = {12{32'sh5555_5555}};
        send_request(r, 1'b0);
        r = {12{32'shAAAA_AAAA}};
        send_request(r, 1'b0);
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.payload = '0;
        res_if.ready  = 1'b0;
        calm          = 1'b0;
        hold_off      = 1'b0;
        sending_done  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 400 && n < 600);
            if (n == 800) hold_off = 1'b1;
            if (n == 1100) wait_drained();   // sender pauses until all results are back
            send_request(make_request(), 1'b1);
        end
        req_if.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Result side: random backpressure, plus one long hold-off of its own.
    initial begin
        int held;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) board.check_result(res_if.payload);
            if (hold_off && held == 0) begin
                held     = 3 * LATENCY;
                hold_off = 1'b0;
            end
            if (held > 0) begin
                held--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/gf_pkg.sv
rtl/gf_if.sv
rtl/gf_front.sv
rtl/gf_recip.sv
rtl/gf_back.sv
rtl/gaussian_fusion_2d.sv
dv/tb_top.sv
